[sv/stable_merge_sort_by_sector_core_defines.svh]
// assertion macros for the sector sorter
`ifndef STABLE_MERGE_SORT_BY_SECTOR_CORE_DEFINES_SVH
`define STABLE_MERGE_SORT_BY_SECTOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SMSORT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, clocked on clk, off during rst
`define SMSORT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[sv/smsort_pkg.sv]
`default_nettype none
package smsort_pkg;

  localparam int SECTOR_W    = 48;
  localparam int TAG_W       = 16;
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 48;
  localparam int KEY_W       = (KEY_BITS < SECTOR_W) ? KEY_BITS : SECTOR_W;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W       = CNT_W + 3;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int WORD_W      = KEY_W + TAG_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             fin;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_EMIT_RD,
    ST_EMIT_WR
  } back_state_t;

  function automatic logic [CNT_W-1:0] seg_bound(input logic [CNT_W-1:0] base,
                                                 input logic [SUM_W-1:0] span,
                                                 input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] lim;
    begin
      sum = SUM_W'(base) + span;
      lim = SUM_W'(n);
      seg_bound = (sum < lim) ? sum[CNT_W-1:0] : n;
    end
  endfunction

  function automatic logic [SECTOR_W-1:0] widen_key(input logic [KEY_W-1:0] key);
    logic [SECTOR_W-1:0] r;
    begin
      r = '0;
      r[KEY_W-1:0] = key;
      widen_key = r;
    end
  endfunction

endpackage
`default_nettype wire

[sv/smsort_ifs.sv]
`default_nettype none
interface smsort_in_if;
  logic                           valid;
  logic                           ready;
  logic [smsort_pkg::SECTOR_W-1:0] sector_key;
  logic [smsort_pkg::TAG_W-1:0]    entry_tag;
  logic                           final_entry;

  modport source (output valid, output sector_key, output entry_tag, output final_entry,
                  input ready);
  modport sink (input valid, input sector_key, input entry_tag, input final_entry,
                output ready);
endinterface

interface smsort_out_if;
  logic                           valid;
  logic                           ready;
  logic [smsort_pkg::SECTOR_W-1:0] sorted_sector;
  logic [smsort_pkg::TAG_W-1:0]    sorted_tag;
  logic                           end_of_run;
  logic                           overflowed;

  modport source (output valid, output sorted_sector, output sorted_tag, output end_of_run,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_sector, input sorted_tag, input end_of_run,
                input overflowed, output ready);
endinterface
`default_nettype wire

[sv/stable_merge_sort_by_sector_core.sv]
// channel   side  payload
// entries   in    sector_key[47:0]  entry_tag[15:0]   final_entry
// results   out   sorted_sector[47:0] sorted_tag[15:0] end_of_run overflowed
//
// entries load at one per cycle while the sorter is loading, through a four-beat queue into one memory
// sorting runs ceil(log2 n) merge passes; each entry takes a read state for the
// memory's registered two-address read, then a compare-and-write state
// emit reads each result in EMIT_RD and registers it in EMIT_WR, which holds under stall
// rst clears queue, counts and result valid; the memory is not cleared
// the queue takes up to four beats while a run sorts or drains, then holds entries off
// results hold under stall
`default_nettype none
module stable_merge_sort_by_sector_core (
  input  logic          clk,
  input  logic          rst,
  smsort_in_if.sink     entries,
  smsort_out_if.source  results
);

  logic               q_valid;
  logic               q_ready;
  smsort_pkg::entry_t q_entry;

  smsort_front u_front (
    .clk     (clk),
    .rst     (rst),
    .entries (entries),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  smsort_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .results (results)
  );

endmodule
`default_nettype wire

[sv/smsort_front.sv]
`default_nettype none
module smsort_front (
  input  logic                clk,
  input  logic                rst,
  smsort_in_if.sink           entries,
  output logic                q_valid,
  input  logic                q_ready,
  output smsort_pkg::entry_t  q_entry
);

  smsort_pkg::entry_t                   fifo [smsort_pkg::QUEUE_DEPTH];
  logic [smsort_pkg::QPTR_W-1:0]        wptr;
  logic [smsort_pkg::QPTR_W-1:0]        rptr;
  logic [smsort_pkg::QCNT_W-1:0]        qcount;
  logic                                 push;
  logic                                 pop;
  smsort_pkg::entry_t                   in_entry;

  assign entries.ready = (qcount != smsort_pkg::QCNT_W'(smsort_pkg::QUEUE_DEPTH));
  assign q_valid       = (qcount != '0);
  assign q_entry       = fifo[rptr];
  assign push          = entries.valid && entries.ready;
  assign pop           = q_valid && q_ready;

  // key trimmed to the stored key width
  always_comb begin
    in_entry.key = entries.sector_key[smsort_pkg::KEY_W-1:0];
    in_entry.tag = entries.entry_tag;
    in_entry.fin = entries.final_entry;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      qcount <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + smsort_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + smsort_pkg::QPTR_W'(1);
      end
      priority if (push && !pop) begin
        qcount <= qcount + smsort_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        qcount <= qcount - smsort_pkg::QCNT_W'(1);
      end else begin
        qcount <= qcount;
      end
    end
  end

endmodule
`default_nettype wire

[sv/smsort_back.sv]
`default_nettype none
module smsort_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  smsort_pkg::entry_t  q_entry,
  smsort_out_if.source        results
);

  localparam int CW = smsort_pkg::CNT_W;
  localparam int SW = smsort_pkg::SUM_W;
  localparam int IW = smsort_pkg::IDX_W;
  localparam int AW = smsort_pkg::ADDR_W;
  localparam int DW = smsort_pkg::WORD_W;
  localparam int KW = smsort_pkg::KEY_W;
  localparam int TW = smsort_pkg::TAG_W;

  smsort_pkg::back_state_t state;
  smsort_pkg::back_state_t state_next;

  // two banks of MAX_ENTRIES words, ping-pong between merge passes
  logic [DW-1:0] mem [2 * smsort_pkg::MAX_ENTRIES];
  logic [DW-1:0] rd_a;
  logic [DW-1:0] rd_b;

  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] o;
  logic [CW-1:0] k;
  logic [SW-1:0] w;
  logic          src;
  logic          ovf;
  logic          run_ovf;

  logic                            out_valid;
  logic [smsort_pkg::SECTOR_W-1:0] out_sector;
  logic [TW-1:0]                   out_tag;
  logic                            out_end;
  logic                            out_ovf;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;
  logic          has_room;
  logic [CW-1:0] cnt_inc;
  logic          ovf_new;
  logic          take_a;
  logic [CW-1:0] o_inc;
  logic          k_last;
  logic          out_load;
  logic          seg_done;
  logic          pass_done;
  logic [SW-1:0] w2;
  logic          sort_done;
  logic [CW-1:0] seg_mid;
  logic [CW-1:0] seg_hi;
  logic [CW-1:0] pass_mid;
  logic [CW-1:0] pass_hi;
  logic [CW-1:0] first_mid;
  logic [CW-1:0] first_hi;

  assign has_room  = (count < CW'(smsort_pkg::MAX_ENTRIES));
  assign cnt_inc   = has_room ? (count + CW'(1)) : count;
  assign ovf_new   = ovf || !has_room;
  assign take_a    = (a < mid) &&
                     ((b >= hi) || (rd_a[DW-1 -: KW] <= rd_b[DW-1 -: KW]));
  assign o_inc     = o + CW'(1);
  assign k_last    = ((k + CW'(1)) == n);
  assign seg_done  = (o_inc == hi);
  assign pass_done = seg_done && (hi == n);
  assign w2        = {w[SW-2:0], 1'b0};
  assign sort_done = pass_done && (w2 >= SW'(n));
  assign seg_mid   = smsort_pkg::seg_bound(hi, w, n);
  assign seg_hi    = smsort_pkg::seg_bound(hi, {w[SW-2:0], 1'b0}, n);
  assign pass_mid  = smsort_pkg::seg_bound('0, w2, n);
  assign pass_hi   = smsort_pkg::seg_bound('0, {w2[SW-2:0], 1'b0}, n);
  assign first_mid = smsort_pkg::seg_bound('0, SW'(1), cnt_inc);
  assign first_hi  = smsort_pkg::seg_bound('0, SW'(2), cnt_inc);
  assign out_load  = (state == smsort_pkg::ST_EMIT_WR) && (!out_valid || results.ready);

  assign results.valid         = out_valid;
  assign results.sorted_sector = out_sector;
  assign results.sorted_tag    = out_tag;
  assign results.end_of_run    = out_end;
  assign results.overflowed    = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smsort_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = {~src, o[IW-1:0]};
    mem_wd     = take_a ? rd_a : rd_b;
    ra_a       = {src, a[IW-1:0]};
    ra_b       = {src, b[IW-1:0]};
    unique case (state)
      smsort_pkg::ST_LOAD: begin
        q_ready = 1'b1;
        mem_wa  = {1'b0, count[IW-1:0]};
        mem_wd  = {q_entry.key, q_entry.tag};
        if (q_valid) begin
          mem_we = has_room;
          if (q_entry.fin) begin
            state_next = (cnt_inc <= CW'(1)) ? smsort_pkg::ST_EMIT_RD
                                             : smsort_pkg::ST_MERGE_RD;
          end
        end
      end
      smsort_pkg::ST_MERGE_RD: begin
        state_next = smsort_pkg::ST_MERGE_WR;
      end
      smsort_pkg::ST_MERGE_WR: begin
        mem_we     = 1'b1;
        state_next = sort_done ? smsort_pkg::ST_EMIT_RD : smsort_pkg::ST_MERGE_RD;
      end
      smsort_pkg::ST_EMIT_RD: begin
        ra_a       = {src, k[IW-1:0]};
        state_next = smsort_pkg::ST_EMIT_WR;
      end
      smsort_pkg::ST_EMIT_WR: begin
        ra_a = {src, k[IW-1:0]};
        if (out_load) begin
          state_next = k_last ? smsort_pkg::ST_LOAD : smsort_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = smsort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ovf     <= 1'b0;
      run_ovf <= 1'b0;
      n       <= '0;
      src     <= 1'b0;
      k       <= '0;
      w       <= SW'(1);
      o       <= '0;
      a       <= '0;
      b       <= '0;
      mid     <= '0;
      hi      <= '0;
    end else begin
      unique case (state)
        smsort_pkg::ST_LOAD: begin
          if (q_valid) begin
            if (q_entry.fin) begin
              count   <= '0;
              ovf     <= 1'b0;
              run_ovf <= ovf_new;
              n       <= cnt_inc;
              src     <= 1'b0;
              k       <= '0;
              w       <= SW'(1);
              o       <= '0;
              a       <= '0;
              mid     <= first_mid;
              b       <= first_mid;
              hi      <= first_hi;
            end else begin
              count <= cnt_inc;
              ovf   <= ovf_new;
            end
          end
        end
        smsort_pkg::ST_MERGE_WR: begin
          priority if (pass_done) begin
            src <= ~src;
            w   <= w2;
            o   <= '0;
            a   <= '0;
            mid <= pass_mid;
            b   <= pass_mid;
            hi  <= pass_hi;
            k   <= '0;
          end else if (seg_done) begin
            o   <= o_inc;
            a   <= hi;
            mid <= seg_mid;
            b   <= seg_mid;
            hi  <= seg_hi;
          end else begin
            o <= o_inc;
            if (take_a) begin
              a <= a + CW'(1);
            end else begin
              b <= b + CW'(1);
            end
          end
        end
        smsort_pkg::ST_EMIT_WR: begin
          if (out_load) begin
            k <= k + CW'(1);
          end
        end
        smsort_pkg::ST_MERGE_RD, smsort_pkg::ST_EMIT_RD: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sector <= smsort_pkg::widen_key(rd_a[DW-1 -: KW]);
      out_tag    <= rd_a[TW-1:0];
      out_end    <= k_last;
      out_ovf    <= run_ovf;
    end
  end

endmodule
`default_nettype wire

[sv/smsort_checker.sv]
`default_nettype none
`include "stable_merge_sort_by_sector_core_defines.svh"
module smsort_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [smsort_pkg::SECTOR_W-1:0] sorted_sector,
  input logic [smsort_pkg::TAG_W-1:0]    sorted_tag,
  input logic                            end_of_run,
  input logic                            overflowed
);

  logic                                             res_beat;
  logic                                             in_run;
  logic [smsort_pkg::SECTOR_W-1:0]                  prev_sector;
  logic                                             prev_ovf;
  logic [smsort_pkg::SECTOR_W+smsort_pkg::TAG_W+1:0] res_payload;

  assign res_beat    = res_valid && res_ready;
  assign res_payload = {sorted_sector, sorted_tag, end_of_run, overflowed};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run      <= 1'b0;
      prev_sector <= '0;
      prev_ovf    <= 1'b0;
    end else if (res_beat) begin
      in_run      <= !end_of_run;
      prev_sector <= sorted_sector;
      prev_ovf    <= overflowed;
    end
  end

  `SMSORT_ASSERT_NEXT(a_valid_held, res_valid && !res_ready, res_valid)
  `SMSORT_ASSERT_NEXT(a_payload_held, res_valid && !res_ready, $stable(res_payload))
  `SMSORT_ASSERT_NOW(a_ascending, res_beat && in_run, sorted_sector >= prev_sector)
  `SMSORT_ASSERT_NOW(a_ovf_per_run, res_beat && in_run, overflowed == prev_ovf)

endmodule

bind stable_merge_sort_by_sector_core smsort_checker u_smsort_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .sorted_sector (results.sorted_sector),
  .sorted_tag    (results.sorted_tag),
  .end_of_run    (results.end_of_run),
  .overflowed    (results.overflowed)
);
`default_nettype wire
